FILE: hdl/bpl_pkg.sv
// ----------------------------------------------------------------------------
// bpl_pkg
// Shared types and constants for the bounded positional list: request and
// status codes, controller states, and the command and status words that
// join the controller to the datapath.
// ----------------------------------------------------------------------------
package bpl_pkg;

	// list geometry
	localparam int CAPACITY   = 64;
	localparam int DATA_WIDTH = 32;
	localparam int IDX_W      = $clog2(CAPACITY);
	localparam int CNT_W      = $clog2(CAPACITY + 1);

	// port widths fixed by the interface
	localparam int REQ_W  = 4;
	localparam int VAL_W  = 32;
	localparam int POS_W  = 7;
	localparam int STAT_W = 2;
	localparam int LEN_W  = 7;

	localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

	// request codes
	typedef enum logic [REQ_W-1:0] {
		REQ_PUSH_FRONT = 4'd0,
		REQ_PUSH_BACK  = 4'd1,
		REQ_INSERT_AT  = 4'd2,
		REQ_POP_FRONT  = 4'd3,
		REQ_DELETE_AT  = 4'd4,
		REQ_POP_BACK   = 4'd5,
		REQ_CLEAR      = 4'd6,
		REQ_REVERSE    = 4'd7,
		REQ_READ_AT    = 4'd8
	} req_t;

	// status codes
	typedef enum logic [STAT_W-1:0] {
		STAT_OK     = 2'd0,
		STAT_BADPOS = 2'd1,
		STAT_EMPTY  = 2'd2,
		STAT_FULL   = 2'd3
	} stat_t;

	// source of the returned value
	typedef enum logic [1:0] {
		SEL_ZERO,
		SEL_HOLD,
		SEL_RDATA
	} sel_t;

	// controller states
	typedef enum logic [3:0] {
		S_IDLE,
		S_DECIDE,
		S_SHIFT_INS,
		S_PUT,
		S_GET,
		S_HOLD,
		S_SHIFT_DEL,
		S_DROP,
		S_RD_OUT,
		S_REV_RD,
		S_REV_WA,
		S_REV_WB
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic  latch;
		logic  setup;
		logic  shift;
		logic  shift_up;
		logic  put;
		logic  rd_idx;
		logic  hold;
		logic  drop;
		logic  clear;
		logic  rev_rd;
		logic  rev_wa;
		logic  rev_wb;
		logic  respond;
		stat_t res_status;
		sel_t  res_sel;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		req_t req;
		logic empty;
		logic full;
		logic ins_bad;
		logic acc_bad;
		logic shift_done;
		logic rev_short;
		logic rev_more;
	} sts_t;

endpackage

FILE: hdl/bounded_positional_list_unit.sv
// ----------------------------------------------------------------------------
// bounded_positional_list_unit
// Ordered list of up to 64 signed words with positional insert, delete,
// read, clear and reverse, one request at a time.
// ----------------------------------------------------------------------------
// Usage:
//   A request word (req_type, value, position) is taken at a rising edge with
//   start high and busy low. busy stays high until the result is issued.
//   Each request gives exactly one result word (read_value, status, length),
//   shown for one cycle with done high; the receiver has no way to stall it,
//   and a new request may be started in the same cycle done is high.
// With n elements held, an insert at 0-based index i moves the n - i elements
// at and above it up, a delete at index i moves the n - 1 - i elements above
// it down, and a reverse swaps floor(n / 2) pairs.
// The element memory has a single write port, so shifts move one element per
// cycle and a reverse writes the low element of each pair and then the high
// one.
// Reset clears the element count and the controller; stored words are not
// cleared and are never read before being written.
// ----------------------------------------------------------------------------
module bounded_positional_list_unit import bpl_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic [REQ_W-1:0]        req_type,
	input  logic signed [VAL_W-1:0] value,
	input  logic [POS_W-1:0]        position,
	output logic                    done,
	output logic signed [VAL_W-1:0] read_value,
	output logic [STAT_W-1:0]       status,
	output logic [LEN_W-1:0]        length
);

	cmd_t cmd;
	sts_t sts;

	// sequencing
	bpl_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.busy   (busy),
		.cmd    (cmd)
	);

	// storage and result path
	bpl_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.req_type   (req_type),
		.value      (value),
		.position   (position),
		.sts        (sts),
		.done       (done),
		.read_value (read_value),
		.status     (status),
		.length     (length)
	);

endmodule

FILE: hdl/bpl_dp.sv
// ----------------------------------------------------------------------------
// bpl_dp
// Datapath of the bounded positional list: element memory with one write
// and two registered read ports, element count, walk pointers, the one-deep
// shift pipeline and the result registers.
// ----------------------------------------------------------------------------
module bpl_dp import bpl_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  cmd_t                    cmd,
	input  logic [REQ_W-1:0]        req_type,
	input  logic signed [VAL_W-1:0] value,
	input  logic [POS_W-1:0]        position,
	output sts_t                    sts,
	output logic                    done,
	output logic signed [VAL_W-1:0] read_value,
	output logic [STAT_W-1:0]       status,
	output logic [LEN_W-1:0]        length
);

	// request word
	req_t                  req_q;
	logic [DATA_WIDTH-1:0] value_q;
	logic [CNT_W-1:0]      pos_q;

	// list state and walk control
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_n;
	logic [CNT_W-1:0] ptr_a_q;
	logic [CNT_W-1:0] ptr_b_q;
	logic [CNT_W-1:0] moves_q;
	logic             valid_s1;
	logic [CNT_W-1:0] addr_s1;
	logic [CNT_W-1:0] idx;

	// memory and read data
	logic [DATA_WIDTH-1:0] mem [CAPACITY];
	logic [DATA_WIDTH-1:0] rdata_a_q;
	logic [DATA_WIDTH-1:0] rdata_b_q;
	logic [DATA_WIDTH-1:0] hold_q;
	logic                  we;
	logic [CNT_W-1:0]      waddr;
	logic [DATA_WIDTH-1:0] wdata;
	logic                  ra_en;
	logic [CNT_W-1:0]      raddr_a;
	logic                  rb_en;
	logic [CNT_W-1:0]      raddr_b;

	// result registers
	logic                  done_q;
	logic [VAL_W-1:0]      read_value_q;
	logic [STAT_W-1:0]     status_q;
	logic [LEN_W-1:0]      length_q;
	logic [DATA_WIDTH-1:0] res_word;

	// target index of the request
	always_comb begin
		case (req_q)
			REQ_PUSH_FRONT: idx = '0;
			REQ_PUSH_BACK:  idx = count_q;
			REQ_INSERT_AT:  idx = pos_q - CNT_W'(1);
			REQ_POP_FRONT:  idx = '0;
			REQ_DELETE_AT:  idx = pos_q - CNT_W'(1);
			REQ_POP_BACK:   idx = count_q - CNT_W'(1);
			REQ_READ_AT:    idx = pos_q - CNT_W'(1);
			default:        idx = '0;
		endcase
	end

	// status toward the controller
	always_comb begin
		sts.req        = req_q;
		sts.empty      = (count_q == '0);
		sts.full       = (count_q >= CAP_CNT);
		sts.ins_bad    = (pos_q == '0) || (pos_q > count_q + CNT_W'(1));
		sts.acc_bad    = (pos_q == '0) || (pos_q > count_q);
		sts.shift_done = (moves_q == '0) && !valid_s1;
		sts.rev_short  = (count_q < CNT_W'(2));
		sts.rev_more   = (ptr_a_q + CNT_W'(2)) < ptr_b_q;
	end

	// memory port selection
	always_comb begin
		we      = 1'b0;
		waddr   = '0;
		wdata   = '0;
		ra_en   = 1'b0;
		raddr_a = '0;
		rb_en   = 1'b0;
		raddr_b = '0;
		if (cmd.shift) begin
			if (moves_q != '0) begin
				ra_en   = 1'b1;
				raddr_a = ptr_a_q;
			end
			if (valid_s1) begin
				we    = 1'b1;
				waddr = cmd.shift_up ? addr_s1 + CNT_W'(1) : addr_s1 - CNT_W'(1);
				wdata = rdata_a_q;
			end
		end
		if (cmd.put) begin
			we    = 1'b1;
			waddr = idx;
			wdata = value_q;
		end
		if (cmd.rd_idx) begin
			ra_en   = 1'b1;
			raddr_a = idx;
		end
		if (cmd.rev_rd) begin
			ra_en   = 1'b1;
			raddr_a = ptr_a_q;
			rb_en   = 1'b1;
			raddr_b = ptr_b_q;
		end
		if (cmd.rev_wa) begin
			we    = 1'b1;
			waddr = ptr_a_q;
			wdata = rdata_b_q;
		end
		if (cmd.rev_wb) begin
			we      = 1'b1;
			waddr   = ptr_b_q;
			wdata   = rdata_a_q;
			ra_en   = 1'b1;
			raddr_a = ptr_a_q + CNT_W'(1);
			rb_en   = 1'b1;
			raddr_b = ptr_b_q - CNT_W'(1);
		end
	end

	// element memory
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr[IDX_W-1:0]] <= wdata;
		end
		if (ra_en) begin
			rdata_a_q <= mem[raddr_a[IDX_W-1:0]];
		end
		if (rb_en) begin
			rdata_b_q <= mem[raddr_b[IDX_W-1:0]];
		end
	end

	// count after this cycle
	always_comb begin
		count_n = count_q;
		if (cmd.clear) begin
			count_n = '0;
		end else if (cmd.put) begin
			count_n = count_q + CNT_W'(1);
		end else if (cmd.drop) begin
			count_n = count_q - CNT_W'(1);
		end
	end

	// count, pointers and shift pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			ptr_a_q  <= '0;
			ptr_b_q  <= '0;
			moves_q  <= '0;
			valid_s1 <= 1'b0;
			req_q    <= REQ_PUSH_FRONT;
		end else begin
			count_q <= count_n;
			if (cmd.latch) begin
				req_q <= req_t'(req_type);
			end
			if (cmd.setup) begin
				valid_s1 <= 1'b0;
				case (req_q)
					REQ_PUSH_FRONT, REQ_PUSH_BACK, REQ_INSERT_AT: begin
						ptr_a_q <= count_q - CNT_W'(1);
						moves_q <= count_q - idx;
					end
					REQ_POP_FRONT, REQ_DELETE_AT, REQ_POP_BACK: begin
						ptr_a_q <= idx + CNT_W'(1);
						moves_q <= count_q - CNT_W'(1) - idx;
					end
					REQ_REVERSE: begin
						ptr_a_q <= '0;
						ptr_b_q <= count_q - CNT_W'(1);
					end
					default: begin
						moves_q <= '0;
					end
				endcase
			end
			if (cmd.shift) begin
				if (moves_q != '0) begin
					valid_s1 <= 1'b1;
					moves_q  <= moves_q - CNT_W'(1);
					ptr_a_q  <= cmd.shift_up ? ptr_a_q - CNT_W'(1) : ptr_a_q + CNT_W'(1);
				end else begin
					valid_s1 <= 1'b0;
				end
			end
			if (cmd.rev_wb) begin
				ptr_a_q <= ptr_a_q + CNT_W'(1);
				ptr_b_q <= ptr_b_q - CNT_W'(1);
			end
		end
	end

	// request payload and shift address
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			value_q <= value[DATA_WIDTH-1:0];
			pos_q   <= CNT_W'(position);
		end
		if (cmd.shift) begin
			addr_s1 <= ptr_a_q;
		end
		if (cmd.hold) begin
			hold_q <= rdata_a_q;
		end
	end

	// returned value source
	always_comb begin
		case (cmd.res_sel)
			SEL_HOLD:  res_word = hold_q;
			SEL_RDATA: res_word = rdata_a_q;
			default:   res_word = '0;
		endcase
	end

	// result word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.respond;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.respond) begin
			read_value_q <= VAL_W'(signed'(res_word));
			status_q     <= cmd.res_status;
			length_q     <= LEN_W'(count_n);
		end
	end

	assign done       = done_q;
	assign read_value = read_value_q;
	assign status     = status_q;
	assign length     = length_q;

	// checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CAP_CNT)
		else $error("element count above capacity");

	a_put_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.put |-> (count_q < CAP_CNT))
		else $error("insert into a full list");

	a_drop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.drop |-> (count_q != '0))
		else $error("delete from an empty list");

	a_single_word: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("result strobe held for two cycles");

	a_full_len: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && status_q == STAT_FULL) |-> (length_q == LEN_W'(CAPACITY)))
		else $error("full status with list not full");

endmodule

FILE: hdl/bpl_ctrl.sv
// ----------------------------------------------------------------------------
// bpl_ctrl
// Controller of the bounded positional list: checks the request against the
// list, then sequences the shift, fetch, reverse and result steps of the
// datapath.
// ----------------------------------------------------------------------------
module bpl_ctrl import bpl_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  sts_t sts,
	output logic busy,
	output cmd_t cmd
);

	state_t state_q;
	state_t state_n;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	// next state
	always_comb begin
		state_n = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) state_n = S_DECIDE;
			end
			S_DECIDE: begin
				case (sts.req)
					REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
						state_n = sts.full ? S_IDLE : S_SHIFT_INS;
					end
					REQ_INSERT_AT: begin
						state_n = (sts.full || sts.ins_bad) ? S_IDLE : S_SHIFT_INS;
					end
					REQ_POP_FRONT, REQ_POP_BACK: begin
						state_n = sts.empty ? S_IDLE : S_GET;
					end
					REQ_DELETE_AT, REQ_READ_AT: begin
						state_n = (sts.empty || sts.acc_bad) ? S_IDLE : S_GET;
					end
					REQ_REVERSE: begin
						state_n = sts.rev_short ? S_IDLE : S_REV_RD;
					end
					default: state_n = S_IDLE;
				endcase
			end
			S_SHIFT_INS: begin
				if (sts.shift_done) state_n = S_PUT;
			end
			S_PUT:       state_n = S_IDLE;
			S_GET:       state_n = (sts.req == REQ_READ_AT) ? S_RD_OUT : S_HOLD;
			S_HOLD:      state_n = S_SHIFT_DEL;
			S_SHIFT_DEL: begin
				if (sts.shift_done) state_n = S_DROP;
			end
			S_DROP:      state_n = S_IDLE;
			S_RD_OUT:    state_n = S_IDLE;
			S_REV_RD:    state_n = S_REV_WA;
			S_REV_WA:    state_n = S_REV_WB;
			S_REV_WB:    state_n = sts.rev_more ? S_REV_WA : S_IDLE;
			default:     state_n = S_IDLE;
		endcase
	end

	// commands
	always_comb begin
		cmd            = '0;
		cmd.res_status = STAT_OK;
		cmd.res_sel    = SEL_ZERO;
		case (state_q)
			S_IDLE: begin
				cmd.latch = start;
			end
			S_DECIDE: begin
				cmd.setup = 1'b1;
				case (sts.req)
					REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
						cmd.respond    = sts.full;
						cmd.res_status = STAT_FULL;
					end
					REQ_INSERT_AT: begin
						cmd.respond    = sts.full || sts.ins_bad;
						cmd.res_status = sts.full ? STAT_FULL : STAT_BADPOS;
					end
					REQ_POP_FRONT, REQ_POP_BACK: begin
						cmd.respond    = sts.empty;
						cmd.res_status = STAT_EMPTY;
					end
					REQ_DELETE_AT, REQ_READ_AT: begin
						cmd.respond    = sts.empty || sts.acc_bad;
						cmd.res_status = sts.empty ? STAT_EMPTY : STAT_BADPOS;
					end
					REQ_CLEAR: begin
						cmd.clear   = 1'b1;
						cmd.respond = 1'b1;
					end
					REQ_REVERSE: begin
						cmd.respond = sts.rev_short;
					end
					default: begin
						cmd.respond = 1'b1;
					end
				endcase
			end
			S_SHIFT_INS: begin
				cmd.shift    = 1'b1;
				cmd.shift_up = 1'b1;
			end
			S_PUT: begin
				cmd.put     = 1'b1;
				cmd.respond = 1'b1;
			end
			S_GET: begin
				cmd.rd_idx = 1'b1;
			end
			S_HOLD: begin
				cmd.hold = 1'b1;
			end
			S_SHIFT_DEL: begin
				cmd.shift = 1'b1;
			end
			S_DROP: begin
				cmd.drop    = 1'b1;
				cmd.respond = 1'b1;
				cmd.res_sel = SEL_HOLD;
			end
			S_RD_OUT: begin
				cmd.respond = 1'b1;
				cmd.res_sel = SEL_RDATA;
			end
			S_REV_RD: begin
				cmd.rev_rd = 1'b1;
			end
			S_REV_WA: begin
				cmd.rev_wa = 1'b1;
			end
			S_REV_WB: begin
				cmd.rev_wb  = 1'b1;
				cmd.respond = !sts.rev_more;
			end
			default: begin
				cmd.respond = 1'b0;
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);

endmodule
